// ===== rtl/ovnh_pkg.sv =====
`timescale 1ns / 1ps

package ovnh_pkg;

    // Number of octave cells in the chain.
    localparam int unsigned OCTAVES    = 8;
    localparam int unsigned OCT_W      = $clog2(OCTAVES);
    // Scaled coordinate: Q.24 frequency applied to Q.16 input, brought back to Q.16.
    localparam int unsigned FREQ_FRAC  = 24;
    localparam int unsigned TOTAL_W    = 56;
    localparam int unsigned WEIGHT_W   = 17;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

    typedef enum logic [7:0] {
        CFG_PERSISTENCE    = 8'd0,
        CFG_BASE_FREQUENCY = 8'd1,
        CFG_HEIGHT_GAIN    = 8'd2,
        CFG_OCTAVE_COUNT   = 8'd3,
        CFG_SEED_OFFSET    = 8'd4
    } t_cfg_idx;

    // Configuration that every octave cell sees.
    typedef struct packed {
        logic [15:0] persistence;
        logic [31:0] base_frequency;
        logic [3:0]  octave_count;
        logic [30:0] seed_offset;
    } t_cfg;

    // What one cell hands to the next along with the request.
    typedef struct packed {
        logic [31:0]                x;
        logic [31:0]                y;
        logic signed [TOTAL_W-1:0]  total;
        logic [WEIGHT_W-1:0]        weight;
    } t_pass;

endpackage

// ===== rtl/ovnh_hash.sv =====
`timescale 1ns / 1ps

module ovnh_hash (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_x,
    input  logic [31:0]        i_y,
    output logic signed [31:0] o_g
);

    localparam logic [31:0] Y_MUL  = 32'd57;
    localparam logic [31:0] C_MUL  = 32'd15731;
    localparam logic [31:0] C_ADD  = 32'd789221;
    localparam logic [31:0] C_LAST = 32'd1376312589;
    localparam logic signed [31:0] G_ONE = 32'sd1073741824;

    logic [31:0] n_n;
    logic [31:0] n_p;
    logic [31:0] w_t;
    logic [31:0] r_n;
    logic [31:0] r_sq;
    logic [31:0] r_n5;
    logic [31:0] r_u;
    logic [31:0] r_n6;
    logic signed [31:0] r_g;

    always_comb begin
        w_t = i_x + i_y * Y_MUL;
        n_n = (w_t << 13) ^ w_t;
        n_p = r_n6 * r_u + C_LAST;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n  <= n_n;
            r_sq <= r_n * r_n;
            r_n5 <= r_n;
            r_u  <= r_sq * C_MUL + C_ADD;
            r_n6 <= r_n5;
            r_g  <= G_ONE - $signed({1'b0, n_p[30:0]});
        end
    end

    assign o_g = r_g;

endmodule

// ===== rtl/ovnh_cell.sv =====
`timescale 1ns / 1ps

module ovnh_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic [ovnh_pkg::OCT_W-1:0]          i_octave,
    input  ovnh_pkg::t_cfg                      i_cfg,
    input  logic                                i_vld,
    input  ovnh_pkg::t_pass                     i_pass,
    output logic                                o_vld,
    output ovnh_pkg::t_pass                     o_pass
);

    // Scale, sign and offset a coordinate product; result is Q.16.
    function automatic logic signed [49:0] scale(input logic [63:0] prod, input logic neg,
                                                 input logic [4:0] sh, input logic [30:0] seed);
        logic [63:0]        s;
        logic signed [49:0] m;
        s = prod >> sh;
        m = $signed({2'b00, s[47:0]});
        return (neg ? -m : m) + $signed({3'b000, seed, 16'h0000});
    endfunction

    // Integer part truncated toward zero, fraction keeps the sign.
    function automatic logic [48:0] split(input logic signed [49:0] v);
        logic [49:0] m;
        logic [31:0] ip;
        logic [16:0] fr;
        m  = v[49] ? 50'(-v) : 50'(v);
        ip = v[49] ? (32'd0 - m[47:16]) : m[47:16];
        fr = v[49] ? (17'd0 - {1'b0, m[15:0]}) : {1'b0, m[15:0]};
        return {ip, fr};
    endfunction

    logic [13:0]         r_vld;
    ovnh_pkg::t_pass     r_pass [1:13];
    ovnh_pkg::t_pass     r_out;

    logic [31:0]         w_mag_a, w_mag_b;
    logic [4:0]          w_sh;
    logic                r_neg_a, r_neg_b;
    logic [63:0]         r_prod_a, r_prod_b;
    logic signed [49:0]  r_v_a, r_v_b;
    logic [48:0]         w_sp_a, w_sp_b;
    logic [31:0]         r_i_a, r_i_b;
    logic signed [16:0]  r_f_a, r_f_b;
    logic signed [33:0]  r_a2_a, r_a2_b, r_a2_a5, r_a2_b5;
    logic signed [16:0]  r_a_a4, r_a_b4;
    logic signed [50:0]  r_a3_a, r_a3_b;
    logic signed [52:0]  w_s_a, w_s_b;
    logic signed [28:0]  r_fa6, r_fb6, r_fa7, r_fb7, r_fa8, r_fb8, r_fb9, r_fb10;
    logic signed [31:0]  w_g [4][4];
    logic signed [35:0]  w_sum [2][2];
    logic signed [25:0]  r_c [2][2];
    logic signed [26:0]  w_d0, w_d1;
    logic signed [55:0]  r_m0, r_m1;
    logic signed [25:0]  r_ca9, r_cb9;
    logic signed [31:0]  r_v1, r_v2, r_v1_11;
    logic signed [32:0]  w_dv;
    logic signed [61:0]  r_m2;
    logic signed [33:0]  r_val;
    logic signed [51:0]  r_con;
    logic [ovnh_pkg::WEIGHT_W-1:0] r_wn;
    logic                w_active;

    // The scaled y coordinate is the first lattice axis, x the second.
    always_comb begin
        w_mag_a  = i_pass.y[31] ? (32'd0 - i_pass.y) : i_pass.y;
        w_mag_b  = i_pass.x[31] ? (32'd0 - i_pass.x) : i_pass.x;
        w_sh     = 5'(ovnh_pkg::FREQ_FRAC) - 5'(i_octave);
        w_sp_a   = split(r_v_a);
        w_sp_b   = split(r_v_b);
        w_s_a    = (53'(r_a2_a5) <<< 17) + (53'(r_a2_a5) <<< 16) - (53'(r_a3_a) <<< 1);
        w_s_b    = (53'(r_a2_b5) <<< 17) + (53'(r_a2_b5) <<< 16) - (53'(r_a3_b) <<< 1);
        w_d0     = 27'(r_c[0][1]) - 27'(r_c[0][0]);
        w_d1     = 27'(r_c[1][1]) - 27'(r_c[1][0]);
        w_dv     = 33'(r_v2) - 33'(r_v1);
        w_active = {1'b0, i_octave} < i_cfg.octave_count;
    end

    genvar gy, gx;
    generate
        for (gy = 0; gy < 4; gy++) begin : g_row
            for (gx = 0; gx < 4; gx++) begin : g_col
                ovnh_hash u_hash (
                    .i_clk (i_clk),
                    .i_en  (i_en),
                    .i_x   (r_i_a + 32'(gx) - 32'd1),
                    .i_y   (r_i_b + 32'(gy) - 32'd1),
                    .o_g   (w_g[gy][gx])
                );
            end
        end
        // Blur the hashes: diagonal neighbours weigh a sixteenth, edge neighbours an eighth and the center a quarter.
        for (gy = 1; gy < 3; gy++) begin : g_cy
            for (gx = 1; gx < 3; gx++) begin : g_cx
                assign w_sum[gy-1][gx-1] =
                    36'(w_g[gy-1][gx-1]) + 36'(w_g[gy-1][gx+1])
                  + 36'(w_g[gy+1][gx-1]) + 36'(w_g[gy+1][gx+1])
                  + ((36'(w_g[gy][gx-1]) + 36'(w_g[gy][gx+1])
                    + 36'(w_g[gy-1][gx]) + 36'(w_g[gy+1][gx])) <<< 1)
                  + (36'(w_g[gy][gx]) <<< 2);
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[12:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pass[1] <= i_pass;
            for (int s = 2; s <= 13; s++) begin
                r_pass[s] <= r_pass[s-1];
            end
            r_neg_a  <= i_pass.y[31];
            r_neg_b  <= i_pass.x[31];
            r_prod_a <= 64'(w_mag_a) * 64'(i_cfg.base_frequency);
            r_prod_b <= 64'(w_mag_b) * 64'(i_cfg.base_frequency);
            r_v_a    <= scale(r_prod_a, r_neg_a, w_sh, i_cfg.seed_offset);
            r_v_b    <= scale(r_prod_b, r_neg_b, w_sh, i_cfg.seed_offset);
            r_i_a    <= w_sp_a[48:17];
            r_f_a    <= $signed(w_sp_a[16:0]);
            r_i_b    <= w_sp_b[48:17];
            r_f_b    <= $signed(w_sp_b[16:0]);
            r_a2_a   <= r_f_a * r_f_a;
            r_a2_b   <= r_f_b * r_f_b;
            r_a_a4   <= r_f_a;
            r_a_b4   <= r_f_b;
            r_a3_a   <= r_a2_a * r_a_a4;
            r_a3_b   <= r_a2_b * r_a_b4;
            r_a2_a5  <= r_a2_a;
            r_a2_b5  <= r_a2_b;
            r_fa6    <= $signed(w_s_a[52:24]);
            r_fb6    <= $signed(w_s_b[52:24]);
            r_fa7    <= r_fa6;
            r_fb7    <= r_fb6;
            r_fa8    <= r_fa7;
            r_fb8    <= r_fb7;
            for (int cy = 0; cy < 2; cy++) begin
                for (int cx = 0; cx < 2; cx++) begin
                    r_c[cy][cx] <= $signed(w_sum[cy][cx][35:10]);
                end
            end
            r_m0     <= w_d0 * r_fa8;
            r_m1     <= w_d1 * r_fa8;
            r_ca9    <= r_c[0][0];
            r_cb9    <= r_c[1][0];
            r_fb9    <= r_fb8;
            r_v1     <= 32'(r_ca9) + $signed(r_m0[55:24]);
            r_v2     <= 32'(r_cb9) + $signed(r_m1[55:24]);
            r_fb10   <= r_fb9;
            r_m2     <= w_dv * r_fb10;
            r_v1_11  <= r_v1;
            r_val    <= 34'(r_v1_11) + 34'($signed(r_m2[61:24]));
            r_con    <= r_val * $signed({1'b0, r_pass[12].weight});
            r_wn     <= ovnh_pkg::WEIGHT_W'((34'(r_pass[12].weight)
                        * 34'(i_cfg.persistence)) >> 16);
            r_out.x      <= r_pass[13].x;
            r_out.y      <= r_pass[13].y;
            r_out.total  <= w_active ? (r_pass[13].total + ovnh_pkg::TOTAL_W'(r_con))
                                     : r_pass[13].total;
            r_out.weight <= r_wn;
        end
    end

    assign o_vld  = r_vld[13];
    assign o_pass = r_out;

endmodule

// ===== rtl/octave_value_noise_height_top.sv =====
`timescale 1ns / 1ps

// Octave value-noise terrain height. Each request carries one Q16.16 sample point and
// produces one saturated Q16.16 height, in request order. The block is a chain of eight
// identical octave cells; every cell is a 14-stage pipeline that computes one octave, adds
// its weighted value to the running sum when that octave is enabled, and hands the request
// to the next cell. A two-stage gain and saturation tail follows, and one request is
// accepted in every cycle while the pipeline is not held. The whole pipeline advances
// together: it holds only while a finished result sits in the output register and the
// downstream side stalls. Configuration is written through a separate port that is always
// ready; write it only while no request is in flight.
module octave_value_noise_height_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_height,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    // Configuration registers, all cleared by reset.
    logic [15:0] r_persistence;
    logic [31:0] r_base_frequency;
    logic [23:0] r_height_gain;
    logic [3:0]  r_octave_count;
    logic [30:0] r_seed_offset;

    ovnh_pkg::t_cfg  w_cfg;
    logic            w_en;
    logic            w_vld  [ovnh_pkg::OCTAVES+1];
    ovnh_pkg::t_pass w_pass [ovnh_pkg::OCTAVES+1];

    logic               r_f1_vld;
    logic signed [56:0] r_q;
    logic signed [40:0] w_h;
    logic signed [31:0] n_height;
    logic               r_out_valid;
    logic signed [31:0] r_height;

    // The configuration port never pushes back.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_persistence    <= '0;
            r_base_frequency <= '0;
            r_height_gain    <= '0;
            r_octave_count   <= '0;
            r_seed_offset    <= '0;
        end else if (i_cfg_valid) begin
            unique case (ovnh_pkg::t_cfg_idx'(i_cfg_index))
                ovnh_pkg::CFG_PERSISTENCE:    r_persistence    <= i_cfg_data[15:0];
                ovnh_pkg::CFG_BASE_FREQUENCY: r_base_frequency <= i_cfg_data;
                ovnh_pkg::CFG_HEIGHT_GAIN:    r_height_gain    <= i_cfg_data[23:0];
                ovnh_pkg::CFG_OCTAVE_COUNT:   r_octave_count   <= i_cfg_data[3:0];
                ovnh_pkg::CFG_SEED_OFFSET:    r_seed_offset    <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.persistence    = r_persistence;
    assign w_cfg.base_frequency = r_base_frequency;
    assign w_cfg.octave_count   = r_octave_count;
    assign w_cfg.seed_offset    = r_seed_offset;

    // The pipeline moves whenever the output register is free or is being drained.
    assign w_en       = ~r_out_valid | ~i_out_stall;
    assign o_in_stall = ~w_en;

    // The first cell starts with an empty sum and a unit octave weight.
    assign w_vld[0]         = i_in_valid;
    assign w_pass[0].x      = i_x_coord;
    assign w_pass[0].y      = i_y_coord;
    assign w_pass[0].total  = '0;
    assign w_pass[0].weight = ovnh_pkg::WEIGHT_ONE;

    // Cells beyond the configured octave count pass the sum through unchanged,
    // so counts above the chain length saturate naturally.
    genvar gc;
    generate
        for (gc = 0; gc < ovnh_pkg::OCTAVES; gc++) begin : g_cell
            ovnh_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (w_en),
                .i_octave (ovnh_pkg::OCT_W'(gc)),
                .i_cfg    (w_cfg),
                .i_vld    (w_vld[gc]),
                .i_pass   (w_pass[gc]),
                .o_vld    (w_vld[gc+1]),
                .o_pass   (w_pass[gc+1])
            );
        end
    endgenerate

    // The Q.40 sum is floored to Q.16 and scaled by the Q8.16 gain.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q <= $signed(w_pass[ovnh_pkg::OCTAVES].total[55:24])
                 * $signed({1'b0, r_height_gain});
        end
    end

    // Drop the gain fraction and clamp to the signed 32-bit range.
    always_comb begin
        w_h = $signed(r_q[56:16]);
        if ((w_h[40:31] == '0) || (w_h[40:31] == '1)) begin
            n_height = w_h[31:0];
        end else if (w_h[40]) begin
            n_height = 32'sh8000_0000;
        end else begin
            n_height = 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_f1_vld    <= w_vld[ovnh_pkg::OCTAVES];
            r_out_valid <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_height <= n_height;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_height    = r_height;

endmodule
